FILE: hw/rtl/pgem_pkg.sv
// ----------------------------------------------------------------------------
// pgem_pkg
// Shared constants, item types and helper functions of the path exclusion
// matcher.
// ----------------------------------------------------------------------------
package pgem_pkg;

    localparam int PATTERNS  = 4;
    localparam int MAX_CHARS = 32;
    localparam int NSTATES   = MAX_CHARS + 1;

    localparam int POS_W  = $clog2(MAX_CHARS);
    localparam int LEN_W  = $clog2(MAX_CHARS + 1);
    localparam int SEEN_W = $clog2(MAX_CHARS + 2);

    localparam int KIND_W   = 1;
    localparam int SLOT_W   = 2;
    localparam int CPOS_W   = 5;
    localparam int CHAR_W   = 8;
    localparam int ACTIVE_W = 3;
    localparam int HIT_W    = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_ACTIVE_PATTERNS = 1'b0;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
    localparam logic [KIND_W-1:0] KIND_PATH = 1'b1;

    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_QUESTION  = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_STAR      = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_CASE_OFS  = 8'h20;

    localparam logic [NSTATES-1:0] NFA_START = NSTATES'(1);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] pattern_slot;
        logic [CPOS_W-1:0] char_position;
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } item_t;

    // Per-cycle command from the top level to every pattern lane.
    typedef struct packed {
        logic              load;
        logic              advance;
        logic              last;
        logic [CHAR_W-1:0] ch;
        logic [CPOS_W-1:0] pos;
        logic [SEEN_W-1:0] seen;
        logic [SEEN_W-1:0] seen_next;
        logic              nonempty;
    } step_t;

    function automatic logic [CHAR_W-1:0] norm_char(input logic [CHAR_W-1:0] raw);
        logic [CHAR_W-1:0] c;
        c = raw;
        if (raw == CH_BACKSLASH)
        begin
            c = CH_SLASH;
        end
        else if (raw >= CH_UPPER_A && raw <= CH_UPPER_Z)
        begin
            c = raw + CH_CASE_OFS;
        end
        return c;
    endfunction

    // Star closure: state j reaches j+1 where pass[j] is set. Runs of stars are
    // resolved with a parallel prefix over ceil(log2(NSTATES)) levels.
    function automatic logic [NSTATES-1:0] close_states(
        input logic [NSTATES-1:0]   s,
        input logic [MAX_CHARS-1:0] pass
    );
        logic [NSTATES-1:0] g;
        logic [NSTATES-1:0] pr;
        logic [NSTATES-1:0] g_n;
        logic [NSTATES-1:0] pr_n;
        g  = s;
        pr = {pass, 1'b0};
        for (int d = 1; d < NSTATES; d = d * 2)
        begin
            for (int k = 0; k < NSTATES; k++)
            begin
                if (k >= d)
                begin
                    g_n[k]  = g[k] | (pr[k] & g[k-d]);
                    pr_n[k] = pr[k] & pr[k-d];
                end
                else
                begin
                    g_n[k]  = g[k];
                    pr_n[k] = 1'b0;
                end
            end
            g  = g_n;
            pr = pr_n;
        end
        return g;
    endfunction

endpackage

FILE: hw/rtl/pgem_ifs.sv
// ----------------------------------------------------------------------------
// pgem_ifs
// Valid/ready channels of the path exclusion matcher: input items and results.
// ----------------------------------------------------------------------------
interface pgem_item_if;
    logic                         valid;
    logic                         ready;
    logic [pgem_pkg::KIND_W-1:0]  kind;
    logic [pgem_pkg::SLOT_W-1:0]  pattern_slot;
    logic [pgem_pkg::CPOS_W-1:0]  char_position;
    logic [pgem_pkg::CHAR_W-1:0]  char_code;
    logic                         last_char;

    modport source (output valid, kind, pattern_slot, char_position, char_code, last_char,
                    input ready);
    modport sink (input valid, kind, pattern_slot, char_position, char_code, last_char,
                  output ready);
endinterface

interface pgem_result_if;
    logic                        valid;
    logic                        ready;
    logic                        excluded;
    logic [pgem_pkg::HIT_W-1:0]  hit_slot;

    modport source (output valid, excluded, hit_slot, input ready);
    modport sink (input valid, excluded, hit_slot, output ready);
endinterface

FILE: hw/rtl/pgem_cfg_regs.sv
// ----------------------------------------------------------------------------
// pgem_cfg_regs
// APB register file holding the number of active patterns.
// ----------------------------------------------------------------------------
module pgem_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pgem_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pgem_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pgem_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [pgem_pkg::ACTIVE_W-1:0]       active_patterns
);

    logic [pgem_pkg::ACTIVE_W-1:0] active_reg;
    logic [pgem_pkg::ACTIVE_W-1:0] active_next;
    logic                          reg_sel;

    // Registers are word aligned; the word index is the address above the byte bits.
    assign reg_sel = (paddr[pgem_pkg::APB_ADDR_W-1] == pgem_pkg::REG_ACTIVE_PATTERNS);

    always_comb
    begin
        active_next = active_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            active_next = pwdata[pgem_pkg::ACTIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    assign prdata = reg_sel ? pgem_pkg::APB_DATA_W'(active_reg) : '0;
    assign pready = 1'b1;
    assign active_patterns = active_reg;

endmodule

FILE: hw/rtl/pgem_lane.sv
// ----------------------------------------------------------------------------
// pgem_lane
// One exclusion pattern: its character cells, its length, and the whole-path,
// component and prefix match state that advances one path character a cycle while step.advance is set.
// ----------------------------------------------------------------------------
module pgem_lane (
    input  logic            clk,
    input  logic            rst_n,
    input  pgem_pkg::step_t step,
    input  logic            wen,
    output logic            match
);

    logic [pgem_pkg::CHAR_W-1:0]  pat_reg [pgem_pkg::MAX_CHARS];
    logic [pgem_pkg::LEN_W-1:0]   len_reg;
    logic [pgem_pkg::LEN_W-1:0]   len_next;
    logic [pgem_pkg::NSTATES-1:0] whole_reg;
    logic [pgem_pkg::NSTATES-1:0] whole_next;
    logic [pgem_pkg::NSTATES-1:0] comp_reg;
    logic [pgem_pkg::NSTATES-1:0] comp_next;
    logic                         hit_reg;
    logic                         hit_next;
    logic                         pre_reg;
    logic                         pre_next;

    logic [pgem_pkg::MAX_CHARS-1:0] in_len;
    logic [pgem_pkg::MAX_CHARS-1:0] star;
    logic [pgem_pkg::MAX_CHARS-1:0] slash;
    logic [pgem_pkg::MAX_CHARS-1:0] eq;
    logic [pgem_pkg::MAX_CHARS-1:0] pass;
    logic [pgem_pkg::MAX_CHARS-1:0] lit_ok;

    logic [pgem_pkg::NSTATES-1:0] whole_cl;
    logic [pgem_pkg::NSTATES-1:0] comp_cl;
    logic [pgem_pkg::NSTATES-1:0] whole_step;
    logic [pgem_pkg::NSTATES-1:0] comp_step;
    logic [pgem_pkg::NSTATES-1:0] whole_adv;
    logic [pgem_pkg::NSTATES-1:0] comp_adv;

    logic                          is_slash;
    logic                          idx_in_len;
    logic                          hit_new;
    logic                          pre_new;
    logic                          slash_end;
    logic                          len_cover;
    logic [pgem_pkg::SEEN_W-1:0]   len_s;
    logic [pgem_pkg::SEEN_W-1:0]   seen_plus;

    // Per-position decode of the stored pattern against the current character.
    always_comb
    begin
        for (int j = 0; j < pgem_pkg::MAX_CHARS; j++)
        begin
            in_len[j] = (pgem_pkg::LEN_W'(j) < len_reg);
            star[j]   = (pat_reg[j] == pgem_pkg::CH_STAR);
            slash[j]  = (pat_reg[j] == pgem_pkg::CH_SLASH);
            eq[j]     = (pat_reg[j] == step.ch);
            pass[j]   = star[j] & in_len[j];
            lit_ok[j] = in_len[j] & ~star[j] & ((pat_reg[j] == pgem_pkg::CH_QUESTION) | eq[j]);
        end
    end

    // One NFA step for both the whole-path and the component automaton.
    always_comb
    begin
        whole_cl   = pgem_pkg::close_states(whole_reg, pass);
        comp_cl    = pgem_pkg::close_states(comp_reg, pass);
        whole_step = '0;
        comp_step  = '0;
        for (int j = 0; j < pgem_pkg::MAX_CHARS; j++)
        begin
            whole_step[j]   = whole_step[j] | (whole_cl[j] & pass[j]);
            whole_step[j+1] = whole_cl[j] & lit_ok[j];
            comp_step[j]    = comp_step[j] | (comp_cl[j] & pass[j]);
            comp_step[j+1]  = comp_cl[j] & lit_ok[j];
        end
        whole_adv = pgem_pkg::close_states(whole_step, pass);
        comp_adv  = pgem_pkg::close_states(comp_step, pass);
    end

    assign is_slash   = (step.ch == pgem_pkg::CH_SLASH);
    assign len_s      = pgem_pkg::SEEN_W'(len_reg);
    assign idx_in_len = (step.seen < len_s);
    assign seen_plus  = pgem_pkg::SEEN_W'(step.seen_next + 1'b1);

    assign hit_new = hit_reg | (is_slash & step.nonempty & comp_cl[len_reg]);
    assign pre_new = pre_reg & ~(idx_in_len & ~eq[step.seen[pgem_pkg::POS_W-1:0]]);

    // A pattern ending in a slash also matches a path that is a prefix of it
    // minus the slash, or that starts with the full pattern.
    assign slash_end = (len_reg != '0) &&
                       slash[pgem_pkg::POS_W'(len_reg - 1'b1)];
    assign len_cover = (step.seen_next >= len_s) || (seen_plus == len_s);

    assign match = whole_adv[len_reg] | hit_new | (~is_slash & comp_adv[len_reg]) |
                   (slash_end & pre_new & len_cover);

    always_comb
    begin
        whole_next = whole_reg;
        comp_next  = comp_reg;
        hit_next   = hit_reg;
        pre_next   = pre_reg;
        len_next   = len_reg;
        if (wen && step.last)
        begin
            len_next = pgem_pkg::LEN_W'(step.pos) + 1'b1;
        end
        if (step.load || (step.advance && step.last))
        begin
            whole_next = pgem_pkg::NFA_START;
            comp_next  = pgem_pkg::NFA_START;
            hit_next   = 1'b0;
            pre_next   = 1'b1;
        end
        else if (step.advance)
        begin
            whole_next = whole_adv;
            comp_next  = is_slash ? pgem_pkg::NFA_START : comp_adv;
            hit_next   = hit_new;
            pre_next   = pre_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            whole_reg <= pgem_pkg::NFA_START;
            comp_reg  <= pgem_pkg::NFA_START;
            hit_reg   <= 1'b0;
            pre_reg   <= 1'b1;
        end
        else
        begin
            len_reg   <= len_next;
            whole_reg <= whole_next;
            comp_reg  <= comp_next;
            hit_reg   <= hit_next;
            pre_reg   <= pre_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            pat_reg[pgem_pkg::POS_W'(step.pos)] <= step.ch;
        end
    end

endmodule

FILE: hw/rtl/path_glob_exclusion_matcher.sv
// ----------------------------------------------------------------------------
// path_glob_exclusion_matcher
// The block takes one item per clock cycle, pattern loads and path characters
// alike: every pattern lane advances its bit-vector NFA across all positions
// when the item held in the input register is processed, so the only thing that
// stops the input is a finished result still waiting in the output register
// while the next end-of-path item is ready to produce another one. A taken item
// is held in the input register until it is processed; its result is then
// registered in the output register and offered from there.
// The pattern cells sit in flip-flops inside each lane, so there is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module path_glob_exclusion_matcher (
    input  logic                            clk,
    input  logic                            rst_n,
    pgem_item_if.sink                       item_in,
    pgem_result_if.source                   result_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pgem_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pgem_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pgem_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    pgem_pkg::item_t               in_reg;
    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic                          in_take;
    logic                          fire;
    logic                          gives_result;

    logic [pgem_pkg::SEEN_W-1:0]   seen_reg;
    logic [pgem_pkg::SEEN_W-1:0]   seen_next;
    logic [pgem_pkg::SEEN_W-1:0]   seen_inc;
    logic                          nonempty_reg;
    logic                          nonempty_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          excluded_reg;
    logic [pgem_pkg::HIT_W-1:0]    hit_slot_reg;

    logic [pgem_pkg::ACTIVE_W-1:0] active_patterns;
    logic [pgem_pkg::CHAR_W-1:0]   ch;
    pgem_pkg::step_t               step;
    logic [pgem_pkg::PATTERNS-1:0] wen;
    logic [pgem_pkg::PATTERNS-1:0] lane_match;
    logic                          any_hit;
    logic [pgem_pkg::HIT_W-1:0]    hit_sel;

    pgem_cfg_regs u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .active_patterns (active_patterns)
    );

    // Input register.
    assign gives_result = (in_reg.kind == pgem_pkg::KIND_PATH) && in_reg.last_char;
    assign fire = in_valid_reg && (!gives_result || !out_valid_reg || result_out.ready);
    assign item_in.ready = !in_valid_reg || fire;
    assign in_take = item_in.valid && item_in.ready;
    assign in_valid_next = in_take || (in_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg.kind          <= item_in.kind;
            in_reg.pattern_slot  <= item_in.pattern_slot;
            in_reg.char_position <= item_in.char_position;
            in_reg.char_code     <= item_in.char_code;
            in_reg.last_char     <= item_in.last_char;
        end
    end

    // Path-wide state shared by all lanes.
    assign ch = pgem_pkg::norm_char(in_reg.char_code);
    assign seen_inc = (seen_reg < pgem_pkg::SEEN_W'(pgem_pkg::MAX_CHARS + 1)) ?
                      pgem_pkg::SEEN_W'(seen_reg + 1'b1) : seen_reg;

    always_comb
    begin
        seen_next     = seen_reg;
        nonempty_next = nonempty_reg;
        if (fire)
        begin
            if (in_reg.kind == pgem_pkg::KIND_LOAD || in_reg.last_char)
            begin
                seen_next     = '0;
                nonempty_next = 1'b0;
            end
            else
            begin
                seen_next     = seen_inc;
                nonempty_next = (ch != pgem_pkg::CH_SLASH);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            nonempty_reg <= 1'b0;
        end
        else
        begin
            seen_reg     <= seen_next;
            nonempty_reg <= nonempty_next;
        end
    end

    always_comb
    begin
        step.load      = fire && (in_reg.kind == pgem_pkg::KIND_LOAD);
        step.advance   = fire && (in_reg.kind == pgem_pkg::KIND_PATH);
        step.last      = in_reg.last_char;
        step.ch        = ch;
        step.pos       = in_reg.char_position;
        step.seen      = seen_reg;
        step.seen_next = seen_inc;
        step.nonempty  = nonempty_reg;
    end

    // Out-of-range loads write nothing but still abandon the current path.
    always_comb
    begin
        for (int p = 0; p < pgem_pkg::PATTERNS; p++)
        begin
            wen[p] = step.load && (in_reg.pattern_slot == p) &&
                     (in_reg.char_position < pgem_pkg::MAX_CHARS);
        end
    end

    for (genvar p = 0; p < pgem_pkg::PATTERNS; p++)
    begin : g_lane
        pgem_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (step),
            .wen   (wen[p]),
            .match (lane_match[p])
        );
    end

    // The lowest active lane that matches wins.
    always_comb
    begin
        any_hit = 1'b0;
        hit_sel = '0;
        for (int p = pgem_pkg::PATTERNS - 1; p >= 0; p--)
        begin
            if (lane_match[p] && (p < active_patterns))
            begin
                any_hit = 1'b1;
                hit_sel = pgem_pkg::HIT_W'(p);
            end
        end
    end

    // Result register.
    assign out_valid_next = (out_valid_reg && !result_out.ready) || (fire && gives_result);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && gives_result)
        begin
            excluded_reg <= any_hit;
            hit_slot_reg <= hit_sel;
        end
    end

    assign result_out.valid    = out_valid_reg;
    assign result_out.excluded = excluded_reg;
    assign result_out.hit_slot = hit_slot_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_out.ready && in_valid_reg && gives_result
        |-> !fire)
        else $error("end-of-path item processed while the result register is full");

    a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        fire && gives_result |=> out_valid_reg)
        else $error("finished path did not produce a result");

    a_load_clears_path: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_reg.kind == pgem_pkg::KIND_LOAD) |=> (seen_reg == '0) && !nonempty_reg)
        else $error("load item did not restart the path state");

    a_seen_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= pgem_pkg::SEEN_W'(pgem_pkg::MAX_CHARS + 1))
        else $error("path character count exceeded its ceiling");

    a_no_hit_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !excluded_reg |-> (hit_slot_reg == '0))
        else $error("hit slot set on a path that was not excluded");

endmodule
